/* src/finger_detect_quick_spo2_top_assert.svh */
// Assertion macros used by the port-level checker of this block
`ifndef FINGER_DETECT_QUICK_SPO2_TOP_ASSERT_SVH
`define FINGER_DETECT_QUICK_SPO2_TOP_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define FDQS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("fdqs check failed");

// antecedent holds -> consequent holds in the next cycle
`define FDQS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("fdqs check failed");

`endif

/* src/fdqs_pkg.sv */
// Types, widths and constants of the finger detect / quick SpO2 block
`default_nettype none
package fdqs_pkg;

	localparam int SAMPLE_BITS   = 18;
	localparam int LEVEL_BITS    = 18;
	localparam int LIMIT_BITS    = 4;
	localparam int HOLD_BITS     = 16;
	localparam int CONF_BITS     = 5;
	localparam int EST_BITS      = 7;
	localparam int CFG_DATA_BITS = 18;
	localparam int CFG_IDX_BITS  = 2;

	localparam int IN_TDATA_BITS  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_BITS = 8;
	localparam int OUT_TUSER_BITS = 2;

	// level compare width covers both the sample and the threshold
	localparam int CMP_BITS = (SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS;

	// quotient bits kept by the divider; anything of 64 or more is discarded
	localparam int QUOT_BITS = 6;
	localparam int PROD_BITS = SAMPLE_BITS + QUOT_BITS;
	localparam int STEP_BITS = $clog2(QUOT_BITS);

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_ON_LEVEL  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_OFF_LEVEL = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_CONF_LIM  = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_HOLD      = 2'd3;

	localparam logic [LEVEL_BITS-1:0] RST_ON_LEVEL  = 18'd60000;
	localparam logic [LEVEL_BITS-1:0] RST_OFF_LEVEL = 18'd30000;
	localparam logic [LIMIT_BITS-1:0] RST_CONF_LIM  = 4'd6;
	localparam logic [HOLD_BITS-1:0]  RST_HOLD      = 16'd1500;

	localparam logic [EST_BITS-1:0]  EST_BASE = 7'd105;
	localparam logic [EST_BITS-1:0]  EST_MAX  = 7'd99;
	localparam logic [EST_BITS-1:0]  EST_MIN  = 7'd70;
	localparam logic [QUOT_BITS-1:0] Q_LIMIT  = 6'd35;

	// command codes on tuser
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	typedef struct packed {
		logic load;      // take the input beat
		logic track;     // confidence update and 35*red product
		logic age_inc;   // tick: advance age
		logic div_init;  // set up divisor
		logic div_step;  // one restoring step
		logic est;       // finish estimate and store
		logic emit;      // load output register
	} cmd_t;

	typedef struct packed {
		logic is_tick;
		logic need_div;
		logic overflow;
	} stat_t;

endpackage
`default_nettype wire

/* src/fdqs_ctrl.sv */
// Sequencer: accepts beats, steps the datapath, owns the output valid
`default_nettype none
module fdqs_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_axis_tvalid,
	output logic                s_axis_tready,
	output logic                m_axis_tvalid,
	input  wire logic           m_axis_tready,
	input  wire fdqs_pkg::stat_t stat,
	output fdqs_pkg::cmd_t      cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_TRACK = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_EST   = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	logic [2:0] state_q, state_d;
	logic [fdqs_pkg::STEP_BITS-1:0] step_q, step_d;
	logic m_valid_q;
	logic out_free;

	assign out_free      = !m_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_TRACK;
				end
			end
			S_TRACK: begin
				if (stat.is_tick) begin
					cmd.age_inc = 1'b1;
					state_d     = S_OUT;
				end else begin
					cmd.track = 1'b1;
					state_d   = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.need_div && !stat.overflow) begin
					cmd.div_init = 1'b1;
					step_d       = fdqs_pkg::STEP_BITS'(fdqs_pkg::QUOT_BITS - 1);
					state_d      = S_DIV;
				end else begin
					state_d = S_OUT;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == '0) begin
					state_d = S_EST;
				end else begin
					step_d = step_q - 1'b1;
				end
			end
			S_EST: begin
				cmd.est = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			step_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			if (cmd.emit) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

/* src/fdqs_dp.sv */
// Datapath: registers, confidence tracking, ratio divider, held estimate
`default_nettype none
module fdqs_dp (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [fdqs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  wire logic [fdqs_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  wire logic                                 in_command,
	input  wire logic [fdqs_pkg::SAMPLE_BITS-1:0]     in_ir,
	input  wire logic [fdqs_pkg::SAMPLE_BITS-1:0]     in_red,
	input  wire fdqs_pkg::cmd_t                       cmd,
	output fdqs_pkg::stat_t                           stat,
	output logic                                      finger_present,
	output logic [fdqs_pkg::EST_BITS-1:0]             spo2_estimate,
	output logic                                      spo2_valid
);

	localparam int SB = fdqs_pkg::SAMPLE_BITS;
	localparam int PB = fdqs_pkg::PROD_BITS;
	localparam int QB = fdqs_pkg::QUOT_BITS;
	localparam int CB = fdqs_pkg::CMP_BITS;

	// configuration
	logic [fdqs_pkg::LEVEL_BITS-1:0] on_level_q, off_level_q;
	logic [fdqs_pkg::LIMIT_BITS-1:0] conf_lim_q;
	logic [fdqs_pkg::HOLD_BITS-1:0]  hold_q;

	// item and divider
	logic            cmd_q;
	logic [SB-1:0]   ir_q, red_q;
	logic [PB-1:0]   rem_q, dvs_q;
	logic [QB-1:0]   quot_q;

	// block state
	logic signed [fdqs_pkg::CONF_BITS-1:0] conf_q;
	logic                                  flag_q;
	logic [fdqs_pkg::EST_BITS-1:0]         held_q;
	logic                                  seen_q;
	logic [fdqs_pkg::HOLD_BITS-1:0]        age_q;

	logic signed [fdqs_pkg::CONF_BITS:0] conf_w, conf_new, lim_w, lim_m1;
	logic [CB-1:0]  ir_cmp, on_cmp, off_cmp;
	logic [PB-1:0]  prod_w, ir_top;
	logic           step_ge;
	logic [fdqs_pkg::EST_BITS-1:0] est_w;
	logic           valid_w;

	assign ir_cmp  = CB'(ir_q);
	assign on_cmp  = CB'(on_level_q);
	assign off_cmp = CB'(off_level_q);
	assign lim_w   = $signed({2'b00, conf_lim_q});
	assign lim_m1  = lim_w - 6'sd1;
	assign conf_w  = (fdqs_pkg::CONF_BITS+1)'(conf_q);

	always_comb begin
		conf_new = conf_w;
		if (ir_cmp > on_cmp) begin
			if (conf_w < lim_w) conf_new = conf_w + 6'sd1;
		end else if (ir_cmp < off_cmp) begin
			if (conf_w > -lim_w) conf_new = conf_w - 6'sd1;
		end
	end

	// 35*red as shifts and adds
	assign prod_w = (PB'(red_q) << 5) + (PB'(red_q) << 1) + PB'(red_q);
	assign ir_top = PB'(ir_q) << QB;
	assign step_ge = (rem_q >= dvs_q);

	assign stat.is_tick  = (cmd_q == fdqs_pkg::CMD_TICK);
	assign stat.need_div = flag_q && (ir_q != '0) && (red_q != '0);
	assign stat.overflow = (rem_q >= ir_top);

	always_comb begin
		est_w = fdqs_pkg::EST_BASE - fdqs_pkg::EST_BITS'(quot_q);
		if (est_w > fdqs_pkg::EST_MAX) est_w = fdqs_pkg::EST_MAX;
	end

	assign valid_w = flag_q && seen_q && (age_q <= hold_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_level_q  <= fdqs_pkg::RST_ON_LEVEL;
			off_level_q <= fdqs_pkg::RST_OFF_LEVEL;
			conf_lim_q  <= fdqs_pkg::RST_CONF_LIM;
			hold_q      <= fdqs_pkg::RST_HOLD;
			conf_q      <= '0;
			flag_q      <= 1'b0;
			held_q      <= '0;
			seen_q      <= 1'b0;
			age_q       <= '0;
			cmd_q       <= fdqs_pkg::CMD_SAMPLE;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					fdqs_pkg::REG_ON_LEVEL:  on_level_q  <= cfg_data[fdqs_pkg::LEVEL_BITS-1:0];
					fdqs_pkg::REG_OFF_LEVEL: off_level_q <= cfg_data[fdqs_pkg::LEVEL_BITS-1:0];
					fdqs_pkg::REG_CONF_LIM:  conf_lim_q  <= cfg_data[fdqs_pkg::LIMIT_BITS-1:0];
					fdqs_pkg::REG_HOLD:      hold_q      <= cfg_data[fdqs_pkg::HOLD_BITS-1:0];
				endcase
			end
			if (cmd.load) cmd_q <= in_command;
			if (cmd.track) begin
				conf_q <= conf_new[fdqs_pkg::CONF_BITS-1:0];
				if (conf_new >= lim_m1) begin
					flag_q <= 1'b1;
				end else if (conf_new <= -lim_m1) begin
					flag_q <= 1'b0;
				end
			end
			if (cmd.age_inc && (age_q != '1)) age_q <= age_q + 1'b1;
			if (cmd.est && (quot_q <= fdqs_pkg::Q_LIMIT) && (est_w >= fdqs_pkg::EST_MIN)) begin
				held_q <= est_w;
				seen_q <= 1'b1;
				age_q  <= '0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ir_q  <= in_ir;
			red_q <= in_red;
		end
		if (cmd.track) rem_q <= prod_w;
		if (cmd.div_init) begin
			dvs_q  <= PB'(ir_q) << (QB - 1);
			quot_q <= '0;
		end else if (cmd.div_step) begin
			if (step_ge) rem_q <= rem_q - dvs_q;
			quot_q <= {quot_q[QB-2:0], step_ge};
			dvs_q  <= dvs_q >> 1;
		end
		if (cmd.emit) begin
			finger_present <= flag_q;
			spo2_valid     <= valid_w;
			spo2_estimate  <= valid_w ? held_q : '0;
		end
	end

endmodule
`default_nettype wire

/* src/finger_detect_quick_spo2_top.sv */
// Top level of the finger detect / quick SpO2 block
// One input beat (sample pair or millisecond tick) gives one output beat. A sample
// beat first moves the finger confidence counter, then, with a finger present and
// both readings nonzero, runs 35*red/ir through a six-step restoring divider
// (one quotient bit a cycle) and holds 105 - quotient, clamped to 99, if it is at
// least 70. The sequencer takes a new beat only from idle, after the previous
// result has been loaded into the output register. The output register lets
// the next beat be worked on while a result waits; a finished result stalls
// the sequencer only while the register is full.
// Configuration writes take effect at once and are meant for idle periods.
`default_nettype none
module finger_detect_quick_spo2_top (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [fdqs_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  wire logic [fdqs_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  wire logic                                  s_axis_tvalid,
	output logic                                       s_axis_tready,
	// ir_sample, red_sample, zero fill
	input  wire logic [fdqs_pkg::IN_TDATA_BITS-1:0]    s_axis_tdata,
	// command
	input  wire logic [0:0]                            s_axis_tuser,
	output logic                                       m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	// spo2_estimate, zero fill
	output logic [fdqs_pkg::OUT_TDATA_BITS-1:0]        m_axis_tdata,
	// finger_present, spo2_valid
	output logic [fdqs_pkg::OUT_TUSER_BITS-1:0]        m_axis_tuser
);

	localparam int SB = fdqs_pkg::SAMPLE_BITS;

	fdqs_pkg::cmd_t  cmd;
	fdqs_pkg::stat_t stat;
	logic                          finger_present, spo2_valid;
	logic [fdqs_pkg::EST_BITS-1:0] spo2_estimate;

	fdqs_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.stat          (stat),
		.cmd           (cmd)
	);

	fdqs_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_command     (s_axis_tuser[0]),
		.in_ir          (s_axis_tdata[SB-1:0]),
		.in_red         (s_axis_tdata[2*SB-1:SB]),
		.cmd            (cmd),
		.stat           (stat),
		.finger_present (finger_present),
		.spo2_estimate  (spo2_estimate),
		.spo2_valid     (spo2_valid)
	);

	assign m_axis_tdata = fdqs_pkg::OUT_TDATA_BITS'(spo2_estimate);
	assign m_axis_tuser = {spo2_valid, finger_present};

endmodule
`default_nettype wire

/* src/fdqs_chk.sv */
// Port-level checks of the finger detect / quick SpO2 block, bound to its top
`default_nettype none
`include "finger_detect_quick_spo2_top_assert.svh"
module fdqs_chk (
	input wire logic                                   clk,
	input wire logic                                   arst_n,
	input wire logic                                   m_axis_tvalid,
	input wire logic                                   m_axis_tready,
	input wire logic [fdqs_pkg::OUT_TDATA_BITS-1:0]    m_axis_tdata,
	input wire logic [fdqs_pkg::OUT_TUSER_BITS-1:0]    m_axis_tuser
);

	// a stalled result beat keeps its contents
	`FDQS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

	// a valid estimate needs a finger
	`FDQS_ASSERT_SAME(a_valid_needs_finger, clk, arst_n, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0])

	// estimate is zero unless valid
	`FDQS_ASSERT_SAME(a_zero_when_invalid, clk, arst_n, m_axis_tvalid && !m_axis_tuser[1], m_axis_tdata == '0)

	// held estimate always lies between the floor and the clamp
	`FDQS_ASSERT_SAME(a_est_range, clk, arst_n, m_axis_tvalid && m_axis_tuser[1], (m_axis_tdata >= 8'd70) && (m_axis_tdata <= 8'd99))

endmodule

bind finger_detect_quick_spo2_top fdqs_chk u_fdqs_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

/* bench/tb_finger_detect_quick_spo2_top.sv */
`timescale 1ns / 100ps
// Testbench for the finger detect / quick SpO2 top level, checked against a predictor
module tb_finger_detect_quick_spo2_top;

	localparam int SAMPLE_BITS    = fdqs_pkg::SAMPLE_BITS;
	localparam int LEVEL_BITS     = fdqs_pkg::LEVEL_BITS;
	localparam int LIMIT_BITS     = fdqs_pkg::LIMIT_BITS;
	localparam int HOLD_BITS      = fdqs_pkg::HOLD_BITS;
	localparam int CONF_BITS      = fdqs_pkg::CONF_BITS;
	localparam int EST_BITS       = fdqs_pkg::EST_BITS;
	localparam int CFG_IDX_BITS   = fdqs_pkg::CFG_IDX_BITS;
	localparam int CFG_DATA_BITS  = fdqs_pkg::CFG_DATA_BITS;
	localparam int IN_TDATA_BITS  = fdqs_pkg::IN_TDATA_BITS;
	localparam int OUT_TDATA_BITS = fdqs_pkg::OUT_TDATA_BITS;
	localparam int OUT_TUSER_BITS = fdqs_pkg::OUT_TUSER_BITS;

	localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 16;

	typedef struct packed {
		logic                finger;
		logic [EST_BITS-1:0] estimate;
		logic                valid;
	} spo2_report_t;

	// Predicts one report per accepted beat and checks the reports that come back
	class spo2_tracker;
		logic [LEVEL_BITS-1:0]       on_level;
		logic [LEVEL_BITS-1:0]       off_level;
		logic [LIMIT_BITS-1:0]       conf_limit;
		logic [HOLD_BITS-1:0]        hold;
		logic signed [CONF_BITS-1:0] confidence;
		logic                        finger;
		logic [EST_BITS-1:0]         held_est;
		logic                        est_seen;
		logic [HOLD_BITS-1:0]        age;
		spo2_report_t                due_reports[$];
		int                          errors;

		function new();
			on_level   = fdqs_pkg::RST_ON_LEVEL;
			off_level  = fdqs_pkg::RST_OFF_LEVEL;
			conf_limit = fdqs_pkg::RST_CONF_LIM;
			hold       = fdqs_pkg::RST_HOLD;
			confidence = '0;
			finger     = 1'b0;
			held_est   = '0;
			est_seen   = 1'b0;
			age        = '0;
			errors     = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_BITS-1:0] idx,
				logic [CFG_DATA_BITS-1:0] val);
			case (idx)
				fdqs_pkg::REG_ON_LEVEL: on_level = val[LEVEL_BITS-1:0];
				fdqs_pkg::REG_OFF_LEVEL: off_level = val[LEVEL_BITS-1:0];
				fdqs_pkg::REG_CONF_LIM: conf_limit = val[LIMIT_BITS-1:0];
				fdqs_pkg::REG_HOLD: hold = val[HOLD_BITS-1:0];
				default: ;
			endcase
		endfunction

		function void absorb_beat(logic cmd, logic [SAMPLE_BITS-1:0] ir,
				logic [SAMPLE_BITS-1:0] red);
			int            lim;
			logic [63:0]   quot;
			logic [EST_BITS-1:0] est;
			spo2_report_t  rep;
			lim = int'(conf_limit);
			if (cmd == fdqs_pkg::CMD_TICK) begin
				if (age != '1)
					age++;
			end else begin
				if (ir > on_level) begin
					if (confidence < lim)
						confidence++;
				end else if (ir < off_level) begin
					if (confidence > -lim)
						confidence--;
				end
				// set test first, so tiny limits flag presence at once
				if (confidence >= lim - 1)
					finger = 1'b1;
				else if (confidence <= -(lim - 1))
					finger = 1'b0;
				if (finger && ir != '0 && red != '0) begin
					quot = (64'd35 * red) / ir;
					if (quot <= 64'd35) begin
						est = fdqs_pkg::EST_BASE - EST_BITS'(quot);
						if (est > fdqs_pkg::EST_MAX)
							est = fdqs_pkg::EST_MAX;
						if (est >= fdqs_pkg::EST_MIN) begin
							held_est = est;
							est_seen = 1'b1;
							age      = '0;
						end
					end
				end
			end
			rep.finger   = finger;
			rep.valid    = finger && est_seen && (age <= hold);
			rep.estimate = rep.valid ? held_est : '0;
			due_reports.push_back(rep);
		endfunction

		function void compare(string what, int want, int got);
			if (want != got) begin
				errors++;
				$display("%0t %s mismatch: expected %0d actual %0d", $time, what, want, got);
			end
		endfunction

		function void check_report(logic [OUT_TDATA_BITS-1:0] data,
				logic [OUT_TUSER_BITS-1:0] user);
			spo2_report_t want;
			if (due_reports.size() == 0) begin
				errors++;
				$display("%0t unexpected beat: expected none actual %0b %0d %0b",
					$time, user[0], data[EST_BITS-1:0], user[1]);
				return;
			end
			want = due_reports.pop_front();
			compare("finger_present", want.finger, user[0]);
			compare("spo2_estimate", want.estimate, data[EST_BITS-1:0]);
			compare("spo2_valid", want.valid, user[1]);
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n         = 1'b0;
	logic                        cfg_we         = 1'b0;
	logic [CFG_IDX_BITS-1:0]     cfg_index      = fdqs_pkg::REG_ON_LEVEL;
	logic [CFG_DATA_BITS-1:0]    cfg_data       = '0;
	logic                        s_axis_tvalid  = 1'b0;
	logic                        s_axis_tready;
	logic [IN_TDATA_BITS-1:0]    s_axis_tdata   = '0;
	logic [0:0]                  s_axis_tuser   = fdqs_pkg::CMD_SAMPLE;
	logic                        m_axis_tvalid;
	logic                        m_axis_tready  = 1'b0;
	logic [OUT_TDATA_BITS-1:0]   m_axis_tdata;
	logic [OUT_TUSER_BITS-1:0]   m_axis_tuser;

	spo2_tracker tracker;
	bit          idle_on = 1'b1;
	int          quiet_cycles = 0;

	finger_detect_quick_spo2_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// beat monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				tracker.absorb_beat(s_axis_tuser[0], s_axis_tdata[SAMPLE_BITS-1:0],
					s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
			if (m_axis_tvalid && m_axis_tready)
				tracker.check_report(m_axis_tdata, m_axis_tuser);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t watchdog: no beat for %0d cycles", $time, quiet_cycles);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// result side back-pressure
	initial begin : sink
		int stall;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 4) == 0) begin
				stall = $urandom_range(1, 17);
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	task automatic send_beat(input logic cmd, input logic [SAMPLE_BITS-1:0] ir,
			input logic [SAMPLE_BITS-1:0] red);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 17);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_TDATA_BITS - 2*SAMPLE_BITS){1'b0}}, red, ir};
		s_axis_tuser  <= cmd;
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	// hold the sender until every outstanding report is back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.due_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic load_settings(input logic [LEVEL_BITS-1:0] on_lv,
			input logic [LEVEL_BITS-1:0] off_lv, input logic [LIMIT_BITS-1:0] lim,
			input logic [HOLD_BITS-1:0] hold_val);
		logic [CFG_DATA_BITS-1:0] vals [4];
		vals[fdqs_pkg::REG_ON_LEVEL]  = CFG_DATA_BITS'(on_lv);
		vals[fdqs_pkg::REG_OFF_LEVEL] = CFG_DATA_BITS'(off_lv);
		vals[fdqs_pkg::REG_CONF_LIM]  = CFG_DATA_BITS'(lim);
		vals[fdqs_pkg::REG_HOLD]      = CFG_DATA_BITS'(hold_val);
		for (int r = 0; r < 4; r++) begin
			cfg_we    <= 1'b1;
			cfg_index <= CFG_IDX_BITS'(r);
			cfg_data  <= vals[r];
			@(posedge clk);
			tracker.write_reg(CFG_IDX_BITS'(r), vals[r]);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [SAMPLE_BITS-1:0] pick_ir(logic [LEVEL_BITS-1:0] on_lv,
			logic [LEVEL_BITS-1:0] off_lv);
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 45 && int'(on_lv) < SAMPLE_MAX)
			return SAMPLE_BITS'($urandom_range(int'(on_lv) + 1, SAMPLE_MAX));
		if (sel < 70 && off_lv != '0)
			return SAMPLE_BITS'($urandom_range(0, int'(off_lv) - 1));
		if (sel < 85 && off_lv <= on_lv)
			return SAMPLE_BITS'($urandom_range(int'(off_lv), int'(on_lv)));
		return SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
	endfunction

	// mostly red/ir ratios that land near the kept range of quotients
	function automatic logic [SAMPLE_BITS-1:0] pick_red(logic [SAMPLE_BITS-1:0] ir);
		int     sel;
		longint v;
		sel = $urandom_range(0, 99);
		if (sel < 10)
			return '0;
		if (sel < 70) begin
			v = longint'(ir) * longint'($urandom_range(0, 38)) / 35;
			v = v + longint'($urandom_range(0, 3));
			if (v > SAMPLE_MAX)
				v = SAMPLE_MAX;
			return SAMPLE_BITS'(v);
		end
		return SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
	endfunction

	initial begin : stim
		logic [SAMPLE_BITS-1:0] ir;
		logic [LEVEL_BITS-1:0]  on_lv;
		tracker = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: tick with nothing held, zero readings, full scale readings
		send_beat(fdqs_pkg::CMD_TICK, '0, '0);
		send_beat(fdqs_pkg::CMD_SAMPLE, '0, '0);
		repeat (6)
			send_beat(fdqs_pkg::CMD_SAMPLE, '1, '1);
		drain();

		load_settings(18'd1000, 18'd500, 4'd2, 16'd3);
		send_beat(fdqs_pkg::CMD_SAMPLE, '1, 18'd1);           // clamps to the top
		send_beat(fdqs_pkg::CMD_SAMPLE, 18'd1, '1);           // quotient far too big
		send_beat(fdqs_pkg::CMD_SAMPLE, 18'd700, 18'd721);    // quotient just above 35
		send_beat(fdqs_pkg::CMD_SAMPLE, 18'd700, '0);         // zero red skips the divide
		repeat (4)
			send_beat(fdqs_pkg::CMD_TICK, '1, '1);            // last one runs past the hold
		send_beat(fdqs_pkg::CMD_SAMPLE, '0, 18'd5);           // zero ir
		repeat (4)
			send_beat(fdqs_pkg::CMD_SAMPLE, '0, '0);
		drain();

		// tiny confidence limits, thresholds at the ends of their range
		load_settings('1, '0, 4'd1, 16'd0);
		send_beat(fdqs_pkg::CMD_SAMPLE, 18'd5, 18'd5);
		drain();
		load_settings('1, '0, 4'd0, 16'd0);
		send_beat(fdqs_pkg::CMD_SAMPLE, 18'd5, 18'd5);
		send_beat(fdqs_pkg::CMD_TICK, '0, '0);
		drain();

		for (int seg = 0; seg < 5; seg++) begin
			if (seg == 4)
				idle_on = 1'b0;
			on_lv = LEVEL_BITS'($urandom_range(1000, 200000));
			load_settings(on_lv, LEVEL_BITS'($urandom_range(0, int'(on_lv))),
				LIMIT_BITS'($urandom_range(0, 15)),
				($urandom_range(0, 4) == 0) ? 16'hFFFF : HOLD_BITS'($urandom_range(0, 40)));
			for (int n = 0; n < 250; n++) begin
				if ($urandom_range(0, 3) == 0) begin
					send_beat(fdqs_pkg::CMD_TICK, SAMPLE_BITS'($urandom),
						SAMPLE_BITS'($urandom));
				end else begin
					ir = pick_ir(tracker.on_level, tracker.off_level);
					send_beat(fdqs_pkg::CMD_SAMPLE, ir, pick_red(ir));
				end
			end
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0 && tracker.due_reports.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
